>>> hdl/fqhs_pkg.sv
// Shared operation codes, status codes and beat layouts for the history-search queue.
package fqhs_pkg;

    localparam int COUNT_W = 11;
    localparam int OUT_DATA_W = 16;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int OUT_STATUS_LSB  = 17;
    localparam int OUT_FOUND_BIT   = 16;
    localparam int OUT_HVALID_BIT  = 35;
    localparam int OUT_PENDING_LSB = 36;

endpackage

>>> hdl/fqhs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fqhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/fifo_queue_with_history_search_core.sv
// Top level of the append-only queue with position reads and membership search.
//
// The s_ channel takes one command beat: push, pop, search a position range for
// a value, or read an entry by position. Every command returns exactly one beat
// on the m_ channel with the popped or read data, the search flag, a status code,
// and a snapshot of the head entry and the pending, stored and head counts.
// Popped entries stay in the entry RAM and remain visible to reads and searches.
// A push, or any command that fails its check, goes from the execute state to
// the done state and then into the output register; a successful pop or read
// adds a wait state for the RAM read, and a search steps through the scanned
// positions in the search state and stops early on a hit. The entry RAM has
// one read port, and a search issues one read per cycle, so the scan length
// sets the search time. A new command is accepted as soon as the previous
// result has moved into the output register. When m_tready is low the result
// beat holds, and one further command may be taken and run to completion
// before the block waits for the receiver. Reset clears the head and write
// pointers and the valid flags; the RAM contents are not cleared, and the
// value of an entry is only used after it has been written.
module fifo_queue_with_history_search_core
    import fqhs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // operation[1:0], value[17:2], position[27:18], range_start[38:28], range_end[49:39]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // data[15:0], found[16], status[18:17], head_value[34:19], head_valid[35],
    // pending_count[46:36], stored_count[57:47], head_position[68:58]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PAD_W = OUT_TDATA_W - 69;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      head_ptr_reg, head_ptr_next;
    logic [CNT_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [DATA_BITS-1:0]  head_val_reg, head_val_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [1:0]            op_reg, op_next;
    logic [15:0]           value_reg, value_next;
    logic [9:0]            pos_reg, pos_next;
    logic [COUNT_W-1:0]    rs_reg, rs_next;
    logic [COUNT_W-1:0]    re_reg, re_next;
    logic [WIDE_W-1:0]     addr_reg, addr_next;
    logic [WIDE_W-1:0]     end_reg, end_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [15:0]           res_data_reg, res_data_next;
    logic                  res_found_reg, res_found_next;
    logic [1:0]            res_status_reg, res_status_next;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_BITS-1:0]  ram_wdata, ram_rdata;

    logic [CNT_W-1:0]      head_inc;
    logic [WIDE_W-1:0]     wp_wide, pos_wide, re_wide;
    logic [CNT_W-1:0]      pending;
    logic                  hit;

    fqhs_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign head_inc = head_ptr_reg + 1'b1;
    assign wp_wide  = WIDE_W'(wr_ptr_reg);
    assign pos_wide = WIDE_W'(pos_reg);
    assign re_wide  = WIDE_W'(re_reg);
    assign pending  = wr_ptr_reg - head_ptr_reg;
    assign hit      = cmp_valid_reg && (ram_rdata == DATA_BITS'(value_reg));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        head_ptr_next   = head_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        head_val_next   = head_val_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        rs_next         = rs_reg;
        re_next         = re_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        cmp_valid_next  = cmp_valid_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[ADDR_W-1:0];
        ram_wdata       = DATA_BITS'(value_reg);
        ram_re          = 1'b0;
        ram_raddr       = addr_reg[ADDR_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[1:0];
                    value_next = s_tdata[17:2];
                    pos_next   = s_tdata[27:18];
                    rs_next    = s_tdata[38:28];
                    re_next    = s_tdata[49:39];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_data_next   = '0;
                res_found_next  = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                unique case (op_reg)
                    OP_PUSH: begin
                        if (wr_ptr_reg >= CNT_W'(DEPTH)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                            if (head_ptr_reg == wr_ptr_reg) begin
                                head_val_next = DATA_BITS'(value_reg);
                            end
                        end
                    end
                    OP_POP: begin
                        if (head_ptr_reg >= wr_ptr_reg) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_data_next = 16'(head_val_reg);
                            head_ptr_next = head_inc;
                            ram_re        = 1'b1;
                            ram_raddr     = head_inc[ADDR_W-1:0];
                            state_next    = S_WAIT;
                        end
                    end
                    OP_SEARCH: begin
                        addr_next      = WIDE_W'(rs_reg);
                        end_next       = (re_wide < wp_wide) ? re_wide : wp_wide;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SEARCH;
                    end
                    OP_READ: begin
                        if (pos_wide >= wp_wide) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_wide[ADDR_W-1:0];
                            state_next = S_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_WAIT: begin
                if (op_reg == OP_POP) begin
                    head_val_next = ram_rdata;
                end else begin
                    res_data_next = 16'(ram_rdata);
                end
                state_next = S_DONE;
            end
            S_SEARCH: begin
                priority if (hit) begin
                    res_found_next = 1'b1;
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                end else if (addr_reg < end_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = addr_reg[ADDR_W-1:0];
                    addr_next      = addr_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end else begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {
                        {PAD_W{1'b0}},
                        COUNT_W'(head_ptr_reg),
                        COUNT_W'(wr_ptr_reg),
                        COUNT_W'(pending),
                        (pending != '0),
                        (pending != '0) ? 16'(head_val_reg) : 16'd0,
                        res_status_reg,
                        res_found_reg,
                        res_data_reg
                    };
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_ptr_reg  <= '0;
            wr_ptr_reg    <= '0;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_ptr_reg  <= head_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            m_valid_reg   <= m_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_val_reg   <= head_val_next;
        m_data_reg     <= m_data_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        rs_reg         <= rs_next;
        re_reg         <= re_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
    end

endmodule

>>> hdl/fqhs_checker.sv
// Port-level checker for the history-search queue, bound to the top level.
module fqhs_checker
    import fqhs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A result beat held by the receiver keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result beat is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A command beat is worked on alone, so the input closes after each acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // The head flag agrees with the pending count, and a hit (which only a search
    // reports) always comes with an ok status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_HVALID_BIT] == (m_tdata[OUT_PENDING_LSB +: COUNT_W] != '0))
                     && (!m_tdata[OUT_FOUND_BIT]
                         || (m_tdata[OUT_STATUS_LSB +: 2] == ST_OK)))
        else $error("inconsistent result beat");

endmodule

bind fifo_queue_with_history_search_core fqhs_checker u_fqhs_checker (.*);

>>> sim/fifo_queue_with_history_search_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the history-search queue: directed table, then random traffic.
module fifo_queue_with_history_search_core_tb;
    import fqhs_pkg::*;

    localparam int QUEUE_DEPTH = 1024;
    localparam int DIR_ROWS = 20;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int TAIL_CYCLES = 1100;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0] data;
        logic        found;
        logic [1:0]  status;
        logic [15:0] head_value;
        logic        head_valid;
        logic [10:0] pending;
        logic [10:0] stored;
        logic [10:0] head_pos;
    } queue_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [15:0]   value;
        logic [9:0]    pos;
        logic [10:0]   range_start;
        logic [10:0]   range_end;
        logic          typed;
        queue_result_t want;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // operation[1:0], value[17:2], position[27:18], range_start[38:28], range_end[49:39]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // data[15:0], found[16], status[18:17], head_value[34:19], head_valid[35],
    // pending_count[46:36], stored_count[57:47], head_position[68:58]
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [15:0]   entry_mirror [0:QUEUE_DEPTH-1];
    int            wr_ptr;
    int            head_ptr;
    logic [15:0]   hot_vals [0:7];
    queue_result_t due_results[$];
    dir_row_t      dir_tab [0:DIR_ROWS-1];
    int            mismatch_count;
    int            beats_seen;
    int            cycle_count;
    bit            quiet;
    bit            long_hold_req;
    bit            long_hold;

    fifo_queue_with_history_search_core #(
        .DEPTH(QUEUE_DEPTH),
        .DATA_BITS(16)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic queue_result_t predict_queue_op(input logic [1:0] op,
                                                       input logic [15:0] v,
                                                       input logic [9:0] pos,
                                                       input logic [10:0] rs,
                                                       input logic [10:0] re);
        queue_result_t r;
        int stop;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (wr_ptr >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    entry_mirror[wr_ptr] = v;
                    wr_ptr++;
                end
            end
            OP_POP: begin
                if (head_ptr >= wr_ptr) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = entry_mirror[head_ptr];
                    head_ptr++;
                end
            end
            OP_SEARCH: begin
                stop = (int'(re) > wr_ptr) ? wr_ptr : int'(re);
                for (int i = int'(rs); i < stop; i++) begin
                    if (entry_mirror[i] == v) r.found = 1'b1;
                end
            end
            default: begin
                if (int'(pos) >= wr_ptr) r.status = ST_RANGE;
                else r.data = entry_mirror[pos];
            end
        endcase
        r.head_valid = (wr_ptr != head_ptr);
        r.head_value = r.head_valid ? entry_mirror[head_ptr] : 16'h0;
        r.pending = 11'(wr_ptr - head_ptr);
        r.stored = 11'(wr_ptr);
        r.head_pos = 11'(head_ptr);
        return r;
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic [15:0] v, input logic [9:0] pos,
                            input logic [10:0] rs, input logic [10:0] re,
                            input queue_result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {6'b0, re, rs, pos, v, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_results.push_back(want);
    endtask

    task automatic random_cmd(input int push_pct);
        logic [1:0]  op;
        logic [15:0] v;
        logic [9:0]  pos;
        logic [10:0] rs;
        logic [10:0] re;
        int          sel;
        int          stop;
        v = 16'($urandom);
        pos = 10'($urandom);
        rs = 11'($urandom);
        re = 11'($urandom);
        if ($urandom_range(0, 99) < push_pct) begin
            op = OP_PUSH;
            if ($urandom_range(0, 1) == 0) v = hot_vals[$urandom_range(0, 7)];
        end else begin
            sel = $urandom_range(0, 2);
            op = (sel == 0) ? OP_POP : (sel == 1) ? OP_SEARCH : OP_READ;
        end
        if (op == OP_SEARCH) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) v = hot_vals[$urandom_range(0, 7)];
            else if (sel < 7 && wr_ptr > 0) v = entry_mirror[$urandom_range(0, wr_ptr - 1)];
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                rs = 11'd0;
                re = 11'h7FF;
            end else if (sel > 1) begin
                rs = 11'($urandom_range(0, wr_ptr));
                stop = int'(rs) + int'($urandom_range(0, 18)) - 2;
                re = (stop < 0) ? 11'd0 : 11'(stop);
            end
        end
        if (op == OP_READ && wr_ptr > 0 && $urandom_range(0, 3) != 0) begin
            pos = 10'($urandom_range(0, wr_ptr - 1));
        end
        send_cmd(op, v, pos, rs, re, predict_queue_op(op, v, pos, rs, re));
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("MISMATCH beat %0d %s: got 0x%0h expected 0x%0h",
                 beats_seen, what, got_v, want_v);
        mismatch_count++;
    endtask

    // The long receiver stall is timed here, apart from the beat checking.
    initial begin
        long_hold = 1'b0;
        wait (long_hold_req);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge aclk);
        long_hold = 1'b0;
    end

    initial begin
        int hold_left;
        queue_result_t got;
        queue_result_t want;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.data = m_tdata[15:0];
                got.found = m_tdata[OUT_FOUND_BIT];
                got.status = m_tdata[OUT_STATUS_LSB +: 2];
                got.head_value = m_tdata[34:19];
                got.head_valid = m_tdata[OUT_HVALID_BIT];
                got.pending = m_tdata[OUT_PENDING_LSB +: COUNT_W];
                got.stored = m_tdata[57:47];
                got.head_pos = m_tdata[68:58];
                if (due_results.size() == 0) begin
                    report_mismatch("beat with nothing expected", 0, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.data !== want.data)
                        report_mismatch("data", got.data, want.data);
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.head_value !== want.head_value)
                        report_mismatch("head_value", got.head_value, want.head_value);
                    if (got.head_valid !== want.head_valid)
                        report_mismatch("head_valid", got.head_valid, want.head_valid);
                    if (got.pending !== want.pending)
                        report_mismatch("pending_count", got.pending, want.pending);
                    if (got.stored !== want.stored)
                        report_mismatch("stored_count", got.stored, want.stored);
                    if (got.head_pos !== want.head_pos)
                        report_mismatch("head_position", got.head_pos, want.head_pos);
                end
                beats_seen++;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (long_hold) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        queue_result_t pred;
        int n;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        wr_ptr = 0;
        head_ptr = 0;
        mismatch_count = 0;
        beats_seen = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        for (int i = 0; i < 8; i++) hot_vals[i] = 16'($urandom);
        dir_tab = '{
            '{OP_POP, 16'h0, 10'd0, 11'd0, 11'd0, 1'b1,
              '{16'h0, 1'b0, ST_EMPTY, 16'h0, 1'b0, 11'd0, 11'd0, 11'd0}},
            '{OP_READ, 16'h0, 10'd0, 11'd0, 11'd0, 1'b1,
              '{16'h0, 1'b0, ST_RANGE, 16'h0, 1'b0, 11'd0, 11'd0, 11'd0}},
            '{OP_SEARCH, 16'h0, 10'd0, 11'd0, 11'd1024, 1'b1,
              '{16'h0, 1'b0, ST_OK, 16'h0, 1'b0, 11'd0, 11'd0, 11'd0}},
            '{OP_PUSH, 16'hFFFF, 10'd0, 11'd0, 11'd0, 1'b1,
              '{16'h0, 1'b0, ST_OK, 16'hFFFF, 1'b1, 11'd1, 11'd1, 11'd0}},
            '{OP_PUSH, 16'h0000, 10'h3FF, 11'h7FF, 11'h7FF, 1'b1,
              '{16'h0, 1'b0, ST_OK, 16'hFFFF, 1'b1, 11'd2, 11'd2, 11'd0}},
            '{OP_PUSH, 16'h8001, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_SEARCH, 16'hFFFF, 10'd0, 11'd0, 11'h7FF, 1'b0, '0},
            '{OP_SEARCH, 16'h8001, 10'd0, 11'd0, 11'd2, 1'b0, '0},
            '{OP_SEARCH, 16'h0000, 10'd0, 11'd2, 11'd1, 1'b0, '0},
            '{OP_SEARCH, 16'h0000, 10'd0, 11'h7FF, 11'h7FF, 1'b0, '0},
            '{OP_READ, 16'hFFFF, 10'h3FF, 11'd0, 11'd0, 1'b1,
              '{16'h0, 1'b0, ST_RANGE, 16'hFFFF, 1'b1, 11'd3, 11'd3, 11'd0}},
            '{OP_READ, 16'h0, 10'd2, 11'd0, 11'd0, 1'b0, '0},
            '{OP_POP, 16'h0, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_POP, 16'h0, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_POP, 16'h0, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_POP, 16'hFFFF, 10'h3FF, 11'h7FF, 11'h7FF, 1'b1,
              '{16'h0, 1'b0, ST_EMPTY, 16'h0, 1'b0, 11'd0, 11'd3, 11'd3}},
            '{OP_READ, 16'h0, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_SEARCH, 16'hFFFF, 10'd0, 11'd0, 11'd3, 1'b0, '0},
            '{OP_PUSH, 16'h5A5A, 10'd0, 11'd0, 11'd0, 1'b0, '0},
            '{OP_SEARCH, 16'h5A5A, 10'd0, 11'd3, 11'd4, 1'b0, '0}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            pred = predict_queue_op(dir_tab[k].op, dir_tab[k].value, dir_tab[k].pos,
                                    dir_tab[k].range_start, dir_tab[k].range_end);
            send_cmd(dir_tab[k].op, dir_tab[k].value, dir_tab[k].pos,
                     dir_tab[k].range_start, dir_tab[k].range_end,
                     dir_tab[k].typed ? dir_tab[k].want : pred);
        end

        // Mostly pushes until the store is full, so later pushes hit the full case.
        n = 0;
        while (wr_ptr < QUEUE_DEPTH) begin
            if (n == 100) long_hold_req = 1'b1;
            if (n == 500) begin
                s_tvalid <= 1'b0;
                while (due_results.size() != 0) @(posedge aclk);
            end
            random_cmd(95);
            n++;
        end
        for (int i = 0; i < 100; i++) begin
            if (i == 60) quiet = 1'b1;
            random_cmd(15);
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
